// ----- rtl/core/knns_pkg.sv -----
// Types and constants shared by the k-nearest-neighbor select block.
package knns_pkg;

    localparam int COORD_W = 32;
    localparam int ABS_W   = 32;
    localparam int SQ_W    = 64;
    localparam int DIST_W  = 63;
    localparam int IDX_W   = 20;
    localparam int RANK_W  = 6;

    localparam logic [DIST_W-1:0] RADIUS_SQ_RESET = 63'd98956046500;
    localparam logic [DIST_W-1:0] EMPTY_SQ_RESET  = 63'd10995116277760000;

    // register index taken from paddr[3]
    localparam logic REG_RADIUS_SQ = 1'b0;
    localparam logic REG_EMPTY_SQ  = 1'b1;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic             first;
        logic             last;
    } t_meta;

    // link from one cell to its right neighbor
    typedef struct packed {
        logic              lt;
        logic [DIST_W-1:0] dist_sq;
        logic [IDX_W-1:0]  idx;
    } t_link;

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        logic [IDX_W-1:0]  idx;
    } t_slot;

    // broadcast to every cell
    typedef struct packed {
        logic              valid;
        logic              keep;
        logic              first;
        logic              load;
        logic              shift;
        logic [IDX_W-1:0]  new_idx;
        logic [DIST_W-1:0] empty;
    } t_ctrl;

endpackage

// ----- rtl/core/knns_dist.sv -----
// Three-stage squared 3-D distance pipeline with 64-bit saturation.
module knns_dist
    import knns_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  logic signed [COORD_W-1:0] i_qx,
    input  logic signed [COORD_W-1:0] i_qy,
    input  logic signed [COORD_W-1:0] i_qz,
    input  logic signed [COORD_W-1:0] i_cx,
    input  logic signed [COORD_W-1:0] i_cy,
    input  logic signed [COORD_W-1:0] i_cz,
    input  t_meta                     i_meta,
    output logic                      o_valid,
    output logic [SQ_W-1:0]           o_dist,
    output t_meta                     o_meta
);

    logic signed [COORD_W:0] w_dx, w_dy, w_dz;
    logic [ABS_W-1:0]        r_ax, r_ay, r_az;
    logic [SQ_W-1:0]         r_sx, r_sy, r_sz;
    logic [SQ_W+1:0]         w_sum;
    logic [SQ_W-1:0]         r_dist;
    logic                    r_v1, r_v2, r_v3;
    t_meta                   r_m1, r_m2, r_m3;

    assign w_dx = (COORD_W+1)'(i_qx) - (COORD_W+1)'(i_cx);
    assign w_dy = (COORD_W+1)'(i_qy) - (COORD_W+1)'(i_cy);
    assign w_dz = (COORD_W+1)'(i_qz) - (COORD_W+1)'(i_cz);

    assign w_sum = (SQ_W+2)'(r_sx) + (SQ_W+2)'(r_sy) + (SQ_W+2)'(r_sz);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ax <= ABS_W'(w_dx[COORD_W] ? -w_dx : w_dx);
        r_ay <= ABS_W'(w_dy[COORD_W] ? -w_dy : w_dy);
        r_az <= ABS_W'(w_dz[COORD_W] ? -w_dz : w_dz);
        r_m1 <= i_meta;
        r_sx <= SQ_W'(r_ax) * SQ_W'(r_ax);
        r_sy <= SQ_W'(r_ay) * SQ_W'(r_ay);
        r_sz <= SQ_W'(r_az) * SQ_W'(r_az);
        r_m2 <= r_m1;
        r_dist <= (w_sum[SQ_W+1:SQ_W] != 2'b00) ? {SQ_W{1'b1}} : w_sum[SQ_W-1:0];
        r_m3 <= r_m2;
    end

    assign o_valid = r_v3;
    assign o_dist  = r_dist;
    assign o_meta  = r_m3;

endmodule

// ----- rtl/core/knns_cell.sv -----
// One rank slot: compare-and-shift insertion cell plus its output shift stage.
module knns_cell
    import knns_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  t_ctrl           i_ctrl,
    input  logic [SQ_W-1:0] i_d,
    input  t_link           i_left,
    output t_link           o_right,
    input  t_slot           i_out_next,
    output t_slot           o_out
);

    t_slot r_slot, n_slot, w_eff;
    t_slot r_out;
    logic  w_lt;

    always_comb begin
        w_eff.dist_sq = i_ctrl.first ? i_ctrl.empty : r_slot.dist_sq;
        w_eff.idx     = i_ctrl.first ? '0 : r_slot.idx;
        w_lt = i_ctrl.keep && (i_d < {1'b0, w_eff.dist_sq});
        if (i_left.lt) begin
            n_slot.dist_sq = i_left.dist_sq;
            n_slot.idx     = i_left.idx;
        end else if (w_lt) begin
            n_slot.dist_sq = i_d[DIST_W-1:0];
            n_slot.idx     = i_ctrl.new_idx;
        end else begin
            n_slot = w_eff;
        end
    end

    assign o_right = '{lt: w_lt, dist_sq: w_eff.dist_sq, idx: w_eff.idx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.dist_sq <= EMPTY_SQ_RESET;
            r_slot.idx     <= '0;
        end else if (i_ctrl.valid) begin
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_out <= n_slot;
        end else if (i_ctrl.shift) begin
            r_out <= i_out_next;
        end
    end

    assign o_out = r_out;

endmodule

// ----- rtl/core/k_nearest_neighbor_select_top.sv -----
// Top level of the k-nearest-neighbor select block: stream ports, registers, cell row.
//
//  channel   dir  beat                                           accepted when
//  s_axis    in   query/candidate coords, index, first, last     s_axis_tvalid & s_axis_tready
//  m_axis    out  one ranked slot, K beats per last candidate    m_axis_tvalid & m_axis_tready
//  apb       in   radius_sq @0x0, empty_distance_sq @0x8         psel & penable & pwrite
//
// Candidates enter one per cycle while s_axis_tready is high, then pass the distance
// pipeline and insertion. A beat with tlast closes input until its K result beats have
// left, paced by m_axis_tready. Reset loads every slot with the reset sentinel; output
// stalls hold the result row and keep input closed.
module k_nearest_neighbor_select_top
    import knns_pkg::*;
#(
    parameter int K_NEIGHBORS = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [31:0] query_x, [63:32] query_y, [95:64] query_z, [127:96] cand_x,
    // [159:128] cand_y, [191:160] cand_z, [211:192] cand_index, [215:212] zero
    input  logic [215:0] s_axis_tdata,
    // [0] first_cand
    input  logic         s_axis_tuser,
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [19:0] neighbor_index, [82:20] neighbor_dist_sq, [88:83] slot_rank, [95:89] zero
    output logic [95:0]  m_axis_tdata,
    output logic         m_axis_tlast,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [3:0]   paddr,
    input  logic [63:0]  pwdata,
    output logic [63:0]  prdata,
    output logic         pready
);

    logic [DIST_W-1:0] r_radius, r_empty;
    logic              r_hold, r_emit;
    logic [RANK_W-1:0] r_rank;
    logic              w_in_acc, w_out_acc, w_cfg_wr, w_rank_end;
    logic              w_d_valid;
    logic [SQ_W-1:0]   w_d;
    t_meta             w_in_meta, w_d_meta;
    t_ctrl             w_ctrl;
    t_link             w_link [K_NEIGHBORS+1];
    t_slot             w_out  [K_NEIGHBORS+1];

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_SQ_RESET;
            r_empty  <= EMPTY_SQ_RESET;
        end else if (w_cfg_wr) begin
            unique case (paddr[3])
                REG_RADIUS_SQ: r_radius <= pwdata[DIST_W-1:0];
                REG_EMPTY_SQ:  r_empty  <= pwdata[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_RADIUS_SQ: prdata = {1'b0, r_radius};
            REG_EMPTY_SQ:  prdata = {1'b0, r_empty};
            default:       prdata = '0;
        endcase
    end

    assign s_axis_tready = !r_hold;
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_in_meta     = '{idx: s_axis_tdata[211:192], first: s_axis_tuser,
                             last: s_axis_tlast};

    knns_dist u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_in_acc),
        .i_qx    (s_axis_tdata[31:0]),
        .i_qy    (s_axis_tdata[63:32]),
        .i_qz    (s_axis_tdata[95:64]),
        .i_cx    (s_axis_tdata[127:96]),
        .i_cy    (s_axis_tdata[159:128]),
        .i_cz    (s_axis_tdata[191:160]),
        .i_meta  (w_in_meta),
        .o_valid (w_d_valid),
        .o_dist  (w_d),
        .o_meta  (w_d_meta)
    );

    assign w_out_acc  = m_axis_tvalid && m_axis_tready;
    assign w_rank_end = (r_rank == RANK_W'(K_NEIGHBORS - 1));

    always_comb begin
        w_ctrl.valid   = w_d_valid;
        w_ctrl.keep    = w_d_valid && (w_d <= {1'b0, r_radius});
        w_ctrl.first   = w_d_valid && w_d_meta.first;
        w_ctrl.load    = w_d_valid && w_d_meta.last;
        w_ctrl.shift   = w_out_acc;
        w_ctrl.new_idx = w_d_meta.idx;
        w_ctrl.empty   = r_empty;
    end

    assign w_link[0]           = '0;
    assign w_out[K_NEIGHBORS]  = '0;

    for (genvar g = 0; g < K_NEIGHBORS; g++) begin : g_cell
        knns_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctrl     (w_ctrl),
            .i_d        (w_d),
            .i_left     (w_link[g]),
            .o_right    (w_link[g+1]),
            .i_out_next (w_out[g+1]),
            .o_out      (w_out[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold <= 1'b0;
            r_emit <= 1'b0;
            r_rank <= '0;
        end else begin
            if (w_in_acc && s_axis_tlast) begin
                r_hold <= 1'b1;
            end
            if (w_ctrl.load) begin
                r_emit <= 1'b1;
                r_rank <= '0;
            end else if (w_out_acc) begin
                if (w_rank_end) begin
                    r_emit <= 1'b0;
                    r_hold <= 1'b0;
                end else begin
                    r_rank <= r_rank + 1'b1;
                end
            end
        end
    end

    assign m_axis_tvalid = r_emit;
    assign m_axis_tlast  = w_rank_end;
    assign m_axis_tdata  = {7'b0, r_rank, w_out[0].dist_sq, w_out[0].idx};

endmodule
